// File: rtl/core/lzss_pkg.sv
// Shared constants and types of the LZSS stream decompressor.
package lzss_pkg;

  localparam int DICT_SIZE = 4096;
  localparam int DICT_AW   = $clog2(DICT_SIZE);
  localparam int MAX_MATCH = 18;
  localparam int MIN_MATCH = 3;
  localparam int FLAG_BITS = 8;
  localparam int CQ_DEPTH  = 2;
  localparam int CQ_AW     = $clog2(CQ_DEPTH);
  localparam int CNT_W     = $clog2(MAX_MATCH + 1);

  localparam logic [DICT_AW-1:0] WP_RESET  = DICT_AW'(DICT_SIZE - MAX_MATCH);
  localparam logic [7:0]         FILL_BYTE = 8'h20;

  typedef enum logic [2:0] {
    PH_FLAG   = 3'b001,
    PH_TOKEN  = 3'b010,
    PH_SECOND = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_COPY  = 3'b100
  } back_state_e;

  // A literal carries its byte in the low bits of pos.
  typedef struct packed {
    logic               is_ref;
    logic [DICT_AW-1:0] pos;
    logic [3:0]         len_nib;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } stat_t;

endpackage

// File: rtl/core/lzss_in_if.sv
// Handshake channel that carries one compressed byte per word.
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// File: rtl/core/lzss_out_if.sv
// Handshake channel that carries one decompressed byte per word.
interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// File: rtl/core/lzss_stream_decompressor.sv
// Top level of the LZSS stream decompressor with a 4096-byte window.
// The input channel in_i takes one compressed byte per word. A flag byte
// supplies eight token bits, least significant first; a set bit marks a
// literal and a clear bit marks a two-byte window reference of 3 to 18 bytes.
// The output channel out_o gives one decoded byte per word and raises last on
// the final byte caused by an input word. Flag bytes and first reference
// bytes produce no output.
// An accepted literal passes through the command queue into the registered
// output word. After the second byte of a reference, the copy engine reads
// the window through its registered read port and the copied bytes follow at
// one byte per cycle while out_o.ready stays high, limited by the single
// write port of the window memory. A reference of up to 18 bytes thus outruns
// its two input words; literals flow at one per cycle under that condition.
// After reset the window is filled with spaces, one byte per cycle over its
// 4096 entries, and in_i.ready stays low during that pass. When the receiver
// holds out_o.ready low, the output word is kept, the copy engine waits, and a
// two-entry command queue lets the parser keep taking input until it fills.
module lzss_stream_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzss_in_if.sink     in_i,
  lzss_out_if.source  out_o
);

  lzss_pkg::stat_t stat;
  lzss_pkg::cmd_t  push_cmd;
  lzss_pkg::cmd_t  head_cmd;
  logic            push, pop, cq_full, cq_valid;

  lzss_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .stat_i    (stat),
    .cq_full_i (cq_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  lzss_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .full_o      (cq_full),
    .valid_o     (cq_valid),
    .data_o      (head_cmd)
  );

  lzss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cq_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .stat_o      (stat),
    .out_o       (out_o)
  );

endmodule

// File: rtl/core/lzss_front.sv
// Front end: parses flag bytes and tokens into literal and reference commands.
module lzss_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  lzss_in_if.sink       in_i,
  input  lzss_pkg::stat_t stat_i,
  input  logic          cq_full_i,
  output logic          push_o,
  output lzss_pkg::cmd_t cmd_o
);

  lzss_pkg::phase_e phase_q, phase_d;
  logic [7:0] flag_q, flag_d;
  logic [3:0] bc_q, bc_d;
  logic [7:0] held_q, held_d;
  logic [3:0] bc_inc;
  logic       accept;

  assign in_i.ready = !cq_full_i && !stat_i.clearing;
  assign accept     = in_i.valid && in_i.ready;
  assign bc_inc     = bc_q + 4'd1;

  always_comb begin
    phase_d = phase_q;
    flag_d  = flag_q;
    bc_d    = bc_q;
    held_d  = held_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    if (accept) begin
      case (phase_q)
        lzss_pkg::PH_TOKEN: begin
          if (flag_q[0]) begin
            push_o         = 1'b1;
            cmd_o.is_ref   = 1'b0;
            cmd_o.pos[7:0] = in_i.in_byte;
            bc_d           = bc_inc;
            flag_d         = flag_q >> 1;
            phase_d        = (bc_inc == 4'(lzss_pkg::FLAG_BITS)) ? lzss_pkg::PH_FLAG
                                                                 : lzss_pkg::PH_TOKEN;
          end else begin
            held_d  = in_i.in_byte;
            phase_d = lzss_pkg::PH_SECOND;
          end
        end
        lzss_pkg::PH_SECOND: begin
          push_o        = 1'b1;
          cmd_o.is_ref  = 1'b1;
          cmd_o.pos     = {in_i.in_byte[7:4], held_q};
          cmd_o.len_nib = in_i.in_byte[3:0];
          bc_d          = bc_inc;
          flag_d        = flag_q >> 1;
          phase_d       = (bc_inc == 4'(lzss_pkg::FLAG_BITS)) ? lzss_pkg::PH_FLAG
                                                              : lzss_pkg::PH_TOKEN;
        end
        default: begin
          flag_d  = in_i.in_byte;
          bc_d    = 4'd0;
          phase_d = lzss_pkg::PH_TOKEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lzss_pkg::PH_FLAG;
      flag_q  <= '0;
      bc_q    <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      bc_q    <= bc_d;
      held_q  <= held_d;
    end
  end

endmodule

// File: rtl/core/lzss_cmd_fifo.sv
// Short command queue between the front end and the copy engine.
module lzss_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzss_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output lzss_pkg::cmd_t data_o
);

  lzss_pkg::cmd_t mem_q [lzss_pkg::CQ_DEPTH];
  logic [lzss_pkg::CQ_AW-1:0] wr_q, rd_q;
  logic [lzss_pkg::CQ_AW:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (lzss_pkg::CQ_AW+1)'(lzss_pkg::CQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (lzss_pkg::CQ_AW+1)'(do_push) - (lzss_pkg::CQ_AW+1)'(do_pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Command pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("Command popped from an empty queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("Queue count did not follow a push.");

endmodule

// File: rtl/core/lzss_back.sv
// Copy engine: owns the window, emits literals and copies references.
module lzss_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  lzss_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  output lzss_pkg::stat_t stat_o,
  lzss_out_if.source      out_o
);

  localparam int AW = lzss_pkg::DICT_AW;
  localparam int CW = lzss_pkg::CNT_W;

  logic [7:0] mem [lzss_pkg::DICT_SIZE];

  lzss_pkg::back_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] rd_pos_q, rd_pos_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          fwd_q;
  logic [7:0]    fwd_data_q;
  logic [7:0]    mem_rd_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  logic          we, emit, emit_last, out_free;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, copy_byte;

  assign out_free        = !out_valid_q || out_o.ready;
  assign copy_byte       = fwd_q ? fwd_data_q : mem_rd_q;
  assign stat_o.clearing = (state_q == lzss_pkg::ST_CLEAR);
  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.last      = out_last_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    rd_pos_d  = rd_pos_q;
    cnt_d     = cnt_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    waddr     = wp_q;
    wdata     = copy_byte;
    raddr     = rd_pos_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    case (state_q)
      lzss_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = lzss_pkg::FILL_BYTE;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = lzss_pkg::ST_IDLE;
        end
      end
      lzss_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.is_ref) begin
            pop_o    = 1'b1;
            raddr    = cmd_i.pos;
            rd_pos_d = cmd_i.pos;
            cnt_d    = CW'(cmd_i.len_nib) + CW'(lzss_pkg::MIN_MATCH);
            state_d  = lzss_pkg::ST_COPY;
          end else if (out_free) begin
            pop_o     = 1'b1;
            we        = 1'b1;
            wdata     = cmd_i.pos[7:0];
            emit      = 1'b1;
            emit_last = 1'b1;
          end
        end
      end
      lzss_pkg::ST_COPY: begin
        if (out_free) begin
          we        = 1'b1;
          emit      = 1'b1;
          emit_last = (cnt_q == CW'(1));
          raddr     = rd_pos_q + 1'b1;
          rd_pos_d  = rd_pos_q + 1'b1;
          cnt_d     = cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_d = lzss_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = lzss_pkg::ST_IDLE;
      end
    endcase
    wp_d = emit ? wp_q + 1'b1 : wp_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata;
    if (emit) begin
      out_byte_q <= wdata;
      out_last_q <= emit_last;
    end
    rd_pos_q <= rd_pos_d;
    cnt_q    <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzss_pkg::ST_CLEAR;
      clr_q       <= '0;
      wp_q        <= lzss_pkg::WP_RESET;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wp_q    <= wp_d;
      fwd_q   <= we && (waddr == raddr);
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == lzss_pkg::ST_COPY) |-> (cnt_q != '0))
    else $error("Copy running with no bytes left.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   emit |=> wp_q == $past(wp_q) + 1'b1)
    else $error("Window pointer did not advance with an output byte.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == lzss_pkg::ST_COPY && emit && cnt_q == CW'(1))
                   |=> (state_q == lzss_pkg::ST_IDLE && out_valid_q && out_last_q))
    else $error("Final copy byte not marked last.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_o.ready) |-> !emit)
    else $error("Output word overwritten while stalled.");

endmodule

// File: bench/lzss_stream_decompressor_test.sv
// Self-checking testbench of the LZSS stream decompressor with a scoreboard of decoded bytes.
module lzss_stream_decompressor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT  = 20000;
  localparam int TARGET_ITEMS = 180;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_word_t;

  class decode_board;
    logic [7:0]                   hist [lzss_pkg::DICT_SIZE];
    logic [lzss_pkg::DICT_AW-1:0] wr_ptr;
    lzss_pkg::phase_e             parse_ph;
    logic [7:0]                   tok_bits;
    logic [3:0]                   tok_used;
    logic [7:0]                   ref_low;
    dec_word_t                    pending_bytes [$];
    int                           errors;

    function new();
      foreach (hist[i]) hist[i] = lzss_pkg::FILL_BYTE;
      wr_ptr   = lzss_pkg::WP_RESET;
      parse_ph = lzss_pkg::PH_FLAG;
      tok_bits = '0;
      tok_used = '0;
      ref_low  = '0;
      errors   = 0;
    endfunction

    function void store_byte(logic [7:0] b, logic lst);
      dec_word_t w;
      w.data = b;
      w.last = lst;
      hist[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      pending_bytes.push_back(w);
    endfunction

    function void next_token();
      tok_used = tok_used + 1'b1;
      tok_bits = tok_bits >> 1;
      parse_ph = (tok_used >= 4'd8) ? lzss_pkg::PH_FLAG : lzss_pkg::PH_TOKEN;
    endfunction

    // Decodes one accepted compressed word and queues the bytes it yields.
    function void take_code(logic [7:0] b);
      logic [lzss_pkg::DICT_AW-1:0] rd;
      logic [7:0]                   v;
      int                           count;
      case (parse_ph)
        lzss_pkg::PH_TOKEN: begin
          if (tok_bits[0]) begin
            store_byte(b, 1'b1);
            next_token();
          end else begin
            ref_low  = b;
            parse_ph = lzss_pkg::PH_SECOND;
          end
        end
        lzss_pkg::PH_SECOND: begin
          rd    = {b[7:4], ref_low};
          count = lzss_pkg::MIN_MATCH + int'(b[3:0]);
          if (count > lzss_pkg::MAX_MATCH) count = lzss_pkg::MAX_MATCH;
          for (int k = 0; k < count; k++) begin
            v = hist[rd];
            store_byte(v, k == count - 1);
            rd = rd + 1'b1;
          end
          next_token();
        end
        default: begin
          tok_bits = b;
          tok_used = '0;
          parse_ph = lzss_pkg::PH_TOKEN;
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task match_byte(logic [7:0] d, logic lst);
      dec_word_t w;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %02h with no word pending", d));
      end else begin
        w = pending_bytes.pop_front();
        if (d !== w.data) report($sformatf("out_byte %02h, want %02h", d, w.data));
        if (lst !== w.last) report($sformatf("last %b, want %b", lst, w.last));
      end
    endtask

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lzss_in_if  in_ch ();
  lzss_out_if out_ch ();

  lzss_stream_decompressor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  decode_board                  board;
  bit                           steady = 1'b0;
  int                           watch_cnt = 0;
  int                           sent = 0;
  logic [lzss_pkg::DICT_AW-1:0] gen_wp;
  logic [7:0]                   directed [26] = '{
    8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
    8'h00, 8'hF2, 8'hFF, 8'hFE, 8'hF0, 8'h00, 8'h0F, 8'h23, 8'h10,
    8'h00, 8'h00, 8'hFD, 8'hF5, 8'h40, 8'h2A, 8'h05, 8'h02
  };

  always #6 clk_i = ~clk_i;

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 19);
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      board.take_code(in_ch.in_byte);
    end
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      board.match_byte(out_ch.out_byte, out_ch.last);
    end
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      watch_cnt = 0;
    end else begin
      watch_cnt++;
    end
    if (watch_cnt >= WATCH_LIMIT) begin
      $display("lzss_stream_decompressor_test NOT OK");
      $finish;
    end
  end

  task automatic send_code(input logic [7:0] b);
    @(negedge clk_i);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  // One flag word and its eight tokens; references mostly point a short way back.
  task automatic send_group(input bit noisy);
    logic [7:0]                   flags;
    logic [7:0]                   hi;
    logic [lzss_pkg::DICT_AW-1:0] src;
    flags = 8'($urandom_range(0, 255));
    send_code(flags);
    for (int i = 0; i < 8; i++) begin
      if (flags[i]) begin
        send_code(8'($urandom_range(0, 255)));
        gen_wp = gen_wp + 1'b1;
      end else begin
        if (noisy) begin
          src = lzss_pkg::DICT_AW'($urandom);
          hi  = 8'($urandom_range(0, 255));
        end else begin
          src = gen_wp - lzss_pkg::DICT_AW'($urandom_range(1, 40));
          hi  = {src[lzss_pkg::DICT_AW-1:8], 4'($urandom_range(0, 15))};
        end
        send_code(src[7:0]);
        send_code(hi);
        gen_wp = gen_wp + lzss_pkg::DICT_AW'(lzss_pkg::MIN_MATCH + int'(hi[3:0]));
      end
    end
  endtask

  initial begin
    int groups;
    board = new();
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Eight literals, then references that overlap their own output, wrap the
    // window end, and read the space-filled region.
    foreach (directed[i]) send_code(directed[i]);
    drain();

    gen_wp = board.wr_ptr;
    groups = 0;
    while (sent < TARGET_ITEMS) begin
      steady = (groups >= 3 && groups < 7);
      if (groups == 9) drain();
      send_group($urandom_range(99) < 20);
      groups++;
    end
    steady = 1'b0;

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("lzss_stream_decompressor_test OK");
    end else begin
      $display("lzss_stream_decompressor_test NOT OK");
    end
    $finish;
  end

endmodule
